// ===== design/dorq_pkg.sv =====
`default_nettype none

package dorq_pkg;

  localparam int DEPTH_DEF        = 32;
  localparam int KEY_BITS_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int FIELD_W    = 64;
  localparam int FILL_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_run;
    logic head_rd;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic enabled;
    op_t  op;
    logic empty;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/dorq_ram.sv =====
`default_nettype none

module dorq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dorq_ctrl.sv =====
`default_nettype none

module dorq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dorq_pkg::dp_stat_t stat,
  output dorq_pkg::ctl_cmd_t ctl
);

  import dorq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.enabled && stat.op == OP_PUSH) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_DECIDE: begin
        if (stat.enabled && stat.op == OP_PUSH) begin
          ctl.scan_init = 1'b1;
        end else if (stat.enabled && (stat.op == OP_POP || stat.op == OP_PEEK) &&
                     !stat.empty) begin
          ctl.head_rd = 1'b1;
        end
      end
      S_SCAN: begin
        ctl.scan_run = 1'b1;
      end
      S_FINISH: begin
        ctl.finish = stat.out_free;
      end
      default: ;
    endcase
  end

  a_accept_decides: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DECIDE)
    else $error("accepted transfer did not move to decide");

  a_scan_push_only: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> stat.op == OP_PUSH && stat.enabled)
    else $error("scan running for a non-push operation");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && !stat.out_free |=> state == S_FINISH)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// ===== design/dorq_dp.sv =====
`default_nettype none

module dorq_dp #(
  parameter int DEPTH        = dorq_pkg::DEPTH_DEF,
  parameter int KEY_BITS     = dorq_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = dorq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dorq_pkg::ctl_cmd_t               ctl,
  output dorq_pkg::dp_stat_t               stat,
  input  logic [1:0]                       cmd,
  input  logic [dorq_pkg::FIELD_W-1:0]     key,
  input  logic [dorq_pkg::FIELD_W-1:0]     payload,
  input  logic                             cfg_valid,
  input  logic [dorq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dorq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic                             overwrote,
  output logic [dorq_pkg::FIELD_W-1:0]     out_key,
  output logic [dorq_pkg::FIELD_W-1:0]     out_payload,
  output logic [dorq_pkg::FILL_W-1:0]      fill
);

  import dorq_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_MAX = (DEPTH < 63) ? DEPTH : 63;
  localparam int AW      = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [FILL_W-1:0] c);
    logic [AW-1:0] n;
    n = AW'(p) + AW'(1);
    if (n >= AW'(c)) begin
      return '0;
    end
    return n[PTR_W-1:0];
  endfunction

  logic [FILL_W-1:0]       capacity;
  logic                    enabled;
  logic [PTR_W-1:0]        head;
  logic [PTR_W-1:0]        tail;
  logic [FILL_W-1:0]       count;
  op_t                     op;
  logic [KEY_BITS-1:0]     lat_key;
  logic [PAYLOAD_BITS-1:0] lat_pl;
  logic [PTR_W-1:0]        scan_ptr;
  logic [FILL_W-1:0]       scan_left;
  logic                    pend;
  logic                    hit;

  logic [FILL_W-1:0]       cap_eff;
  logic                    full;
  logic                    empty;
  logic                    out_free;
  logic                    rd_en;
  logic [PTR_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [KEY_BITS-1:0]     key_rd;
  logic [PAYLOAD_BITS-1:0] pl_rd;

  status_t             res_status;
  logic                res_over;
  logic [FIELD_W-1:0]  res_key;
  logic [FIELD_W-1:0]  res_pl;
  logic [FILL_W-1:0]   res_fill;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = FILL_W'(1);
    end else if (AW'(capacity) > AW'(CAP_MAX)) begin
      cap_eff = FILL_W'(CAP_MAX);
    end else begin
      cap_eff = capacity;
    end
  end

  assign full     = count >= cap_eff;
  assign empty    = count == '0;
  assign out_free = !out_valid || out_ready;

  assign stat.enabled   = enabled;
  assign stat.op        = op;
  assign stat.empty     = empty;
  assign stat.scan_done = (scan_left == '0) && !pend;
  assign stat.out_free  = out_free;

  assign rd_en   = ctl.head_rd || (ctl.scan_run && scan_left != '0);
  assign rd_addr = ctl.head_rd ? head : scan_ptr;
  assign wr_en   = ctl.finish && enabled && op == OP_PUSH && !hit;

  dorq_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (lat_key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  dorq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_pl_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (lat_pl),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (pl_rd)
  );

  always_comb begin
    res_status = ST_OK;
    res_over   = 1'b0;
    res_key    = '0;
    res_pl     = '0;
    res_fill   = count;
    if (!enabled) begin
      res_status = ST_DISABLED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (hit) begin
            res_status = ST_DUP;
          end else begin
            res_over = full;
            if (!full) begin
              res_fill = count + FILL_W'(1);
            end
          end
        end
        OP_POP, OP_PEEK: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_key = FIELD_W'(key_rd);
            res_pl  = FIELD_W'(pl_rd);
            if (op == OP_POP) begin
              res_fill = count - FILL_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          res_fill = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      enabled   <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      scan_ptr  <= '0;
      scan_left <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
    end else begin
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAPACITY: begin
            capacity <= cfg_data;
            head     <= '0;
            tail     <= '0;
            count    <= '0;
          end
          CFG_ENABLED: begin
            enabled <= cfg_data[0];
            head    <= '0;
            tail    <= '0;
            count   <= '0;
          end
          default: ;
        endcase
      end else if (ctl.finish && enabled) begin
        case (op)
          OP_PUSH: begin
            if (!hit) begin
              if (full) begin
                head <= adv(head, cap_eff);
              end else begin
                count <= count + FILL_W'(1);
              end
              tail <= adv(tail, cap_eff);
            end
          end
          OP_POP: begin
            if (!empty) begin
              head  <= adv(head, cap_eff);
              count <= count - FILL_W'(1);
            end
          end
          OP_CLEAR: begin
            head  <= '0;
            tail  <= '0;
            count <= '0;
          end
          default: ;
        endcase
      end

      if (ctl.scan_init) begin
        scan_ptr  <= head;
        scan_left <= count;
        pend      <= 1'b0;
        hit       <= 1'b0;
      end else if (ctl.scan_run) begin
        if (scan_left != '0) begin
          scan_ptr  <= adv(scan_ptr, cap_eff);
          scan_left <= scan_left - FILL_W'(1);
        end
        pend <= scan_left != '0;
        if (pend && key_rd == lat_key) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op      <= op_t'(cmd);
      lat_key <= key[KEY_BITS-1:0];
      lat_pl  <= payload[PAYLOAD_BITS-1:0];
    end
    if (ctl.finish) begin
      status      <= res_status;
      overwrote   <= res_over;
      out_key     <= res_key;
      out_payload <= res_pl;
      fill        <= res_fill;
    end
  end

  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap_eff)
    else $error("entry count above capacity");

  a_ptrs_in_cap: assert property (@(posedge clk) disable iff (rst)
    (AW'(head) < AW'(cap_eff)) && (AW'(tail) < AW'(cap_eff)))
    else $error("pointer outside capacity");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    ctl.finish && !cfg_valid && enabled && op == OP_POP && !empty
    |=> count == $past(count) - FILL_W'(1))
    else $error("pop did not remove an entry");

endmodule

`default_nettype wire

// ===== design/dedup_overwrite_ring_queue.sv =====
// Circular record queue with duplicate-key rejection and overwrite of the
// oldest entry when full.
// Input channel (in_valid/in_ready): cmd, key, payload. One transfer is taken
// at a time; in_ready is high only while no operation is in progress.
// Output channel (out_valid/out_ready): status, overwrote, out_key,
// out_payload, fill; exactly one result per input transfer.
// Config channel (cfg_valid/cfg_ready): index 0 capacity, index 1 enabled; a
// write to either index empties the queue. Write only while the queue is idle.
// Pop, peek, clear and any command while disabled pass from decide to finish;
// an enabled push also runs the key scan between them, which reads one stored
// key per cycle from the key RAM.
// A new transfer is taken only once the result of the last one is registered.
// Reset: queue empty, capacity 32, disabled, output channel empty.
// A stalled receiver holds the result in the output register; the next
// transfer is taken meanwhile and its result waits until that one is taken.
`default_nettype none

module dedup_overwrite_ring_queue #(
  parameter int DEPTH        = dorq_pkg::DEPTH_DEF,
  parameter int KEY_BITS     = dorq_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = dorq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [dorq_pkg::FIELD_W-1:0]     key,
  input  logic [dorq_pkg::FIELD_W-1:0]     payload,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic                             overwrote,
  output logic [dorq_pkg::FIELD_W-1:0]     out_key,
  output logic [dorq_pkg::FIELD_W-1:0]     out_payload,
  output logic [dorq_pkg::FILL_W-1:0]      fill,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dorq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dorq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import dorq_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  dorq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  dorq_dp #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cmd         (cmd),
    .key         (key),
    .payload     (payload),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .overwrote   (overwrote),
    .out_key     (out_key),
    .out_payload (out_payload),
    .fill        (fill)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dorq_pkg::*;

  localparam int SLOTS       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 40;

  typedef struct {
    op_t                op;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] payload;
  } ring_op_t;

  typedef struct {
    status_t            status;
    logic               overwrote;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] payload;
    logic [FILL_W-1:0]  fill;
  } ring_ans_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            cmd = OP_PUSH;
  logic [FIELD_W-1:0]    key = '0;
  logic [FIELD_W-1:0]    payload = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic                  overwrote;
  logic [FIELD_W-1:0]    out_key;
  logic [FIELD_W-1:0]    out_payload;
  logic [FILL_W-1:0]     fill;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted queue contents and settings
  logic [FIELD_W-1:0] key_mem [SLOTS];
  logic [FIELD_W-1:0] pay_mem [SLOTS];
  int                 head_idx = 0;
  int                 tail_idx = 0;
  int                 used = 0;
  logic [FILL_W-1:0]  cap_reg = CAP_RESET;
  logic               en_reg = 1'b0;

  ring_op_t           op_backlog [$];
  ring_ans_t          ring_answers [$];
  logic [FIELD_W-1:0] key_pool [POOL_SIZE];

  logic in_xfer = 1'b0;
  int   send_idle = 8;
  int   recv_idle = 65;
  int   items_issued = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   cycles = 0;

  dedup_overwrite_ring_queue u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .key        (key),
    .payload    (payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .overwrote  (overwrote),
    .out_key    (out_key),
    .out_payload(out_payload),
    .fill       (fill),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_cap(logic [FILL_W-1:0] code);
    if (code == 0) return 1;
    if (code > SLOTS) return SLOTS;
    return code;
  endfunction

  function automatic int ring_next(int p);
    return (p + 1 >= eff_cap(cap_reg)) ? 0 : p + 1;
  endfunction

  function automatic void ring_clear();
    head_idx = 0;
    tail_idx = 0;
    used = 0;
  endfunction

  function automatic void ring_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_CAPACITY) begin
      cap_reg = val;
      ring_clear();
    end else if (idx == CFG_ENABLED) begin
      en_reg = val[0];
      ring_clear();
    end
  endfunction

  function automatic ring_ans_t ring_apply(ring_op_t r);
    ring_ans_t a;
    int        idx;
    logic      dup;
    a.status = ST_OK;
    a.overwrote = 1'b0;
    a.key = '0;
    a.payload = '0;
    if (!en_reg) begin
      a.status = ST_DISABLED;
    end else begin
      case (r.op)
        OP_PUSH: begin
          dup = 1'b0;
          idx = head_idx;
          for (int i = 0; i < used; i++) begin
            if (key_mem[idx] == r.key) dup = 1'b1;
            idx = ring_next(idx);
          end
          if (dup) begin
            a.status = ST_DUP;
          end else begin
            if (used >= eff_cap(cap_reg)) begin
              head_idx = ring_next(head_idx);
              used--;
              a.overwrote = 1'b1;
            end
            key_mem[tail_idx] = r.key;
            pay_mem[tail_idx] = r.payload;
            tail_idx = ring_next(tail_idx);
            used++;
          end
        end
        OP_POP, OP_PEEK: begin
          if (used == 0) begin
            a.status = ST_EMPTY;
          end else begin
            a.key = key_mem[head_idx];
            a.payload = pay_mem[head_idx];
            if (r.op == OP_POP) begin
              head_idx = ring_next(head_idx);
              used--;
            end
          end
        end
        default: ring_clear();
      endcase
    end
    a.fill = FILL_W'(used);
    return a;
  endfunction

  task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // driver: new transfer offered at the falling edge
  always @(negedge clk) begin : drive
    ring_op_t nxt;
    out_ready <= ($urandom_range(99) >= recv_idle);
    if (!rst && (!in_valid || in_xfer)) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = op_backlog.pop_front();
        in_valid <= 1'b1;
        cmd <= nxt.op;
        key <= nxt.key;
        payload <= nxt.payload;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks result transfers, predicts on input transfers
  always @(posedge clk) begin : watch
    ring_ans_t want;
    ring_op_t  req;
    in_xfer <= in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (ring_answers.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        want = ring_answers.pop_front();
        check_field("status", want.status, status);
        check_field("overwrote", want.overwrote, overwrote);
        check_field("out_key", want.key, out_key);
        check_field("out_payload", want.payload, out_payload);
        check_field("fill", want.fill, fill);
      end
      results_seen++;
    end
    if (!rst && in_valid && in_ready) begin
      req.op = op_t'(cmd);
      req.key = key;
      req.payload = payload;
      ring_answers.push_back(ring_apply(req));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_op(op_t op, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] pl);
    ring_op_t r;
    r.op = op;
    r.key = k;
    r.payload = pl;
    op_backlog.push_back(r);
    items_issued++;
  endtask

  task automatic queue_random(logic [FILL_W-1:0] cap_code);
    int               span;
    int               r;
    op_t              op;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] pl;
    span = eff_cap(cap_code) + 6;
    if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
    r = $urandom_range(99);
    if (r < 55) op = OP_PUSH;
    else if (r < 75) op = OP_POP;
    else if (r < 96) op = OP_PEEK;
    else op = OP_CLEAR;
    if ($urandom_range(3) == 0) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(span)];
    case ($urandom_range(15))
      0: pl = '0;
      1: pl = '1;
      default: pl = {$urandom, $urandom};
    endcase
    queue_op(op, k, pl);
  endtask

  task automatic drain();
    while (results_seen != items_issued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    ring_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stim
    int caps [10];
    logic [FIELD_W-1:0] ka;
    logic [FIELD_W-1:0] kb;
    caps = '{32, 63, 1, 2, 5, 17, 31, 33, 0, 3};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    ka = {$urandom, $urandom};
    kb = ~ka;

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // disabled after reset, clear included
    queue_op(OP_PUSH, '0, '0);
    queue_op(OP_POP, '0, '0);
    queue_op(OP_PEEK, '1, '1);
    queue_op(OP_CLEAR, '0, '0);
    drain();

    write_reg(CFG_ENABLED, CFG_DATA_W'(1));
    queue_op(OP_POP, '0, '0);
    queue_op(OP_PEEK, '0, '0);
    queue_op(OP_PUSH, '0, '0);
    queue_op(OP_PUSH, '1, '1);
    queue_op(OP_PUSH, '0, ka);
    queue_op(OP_PUSH, '1, kb);
    queue_op(OP_PEEK, '0, '0);
    queue_op(OP_POP, '0, '0);
    queue_op(OP_POP, '0, '0);
    queue_op(OP_POP, '0, '0);
    queue_op(OP_PUSH, ka, kb);
    queue_op(OP_PUSH, kb, ka);
    queue_op(OP_CLEAR, '0, '0);
    queue_op(OP_PEEK, '0, '0);
    drain();

    // capacity zero behaves as one: second push overwrites
    write_reg(CFG_CAPACITY, CFG_DATA_W'(0));
    queue_op(OP_PUSH, ka, ka);
    queue_op(OP_PUSH, kb, kb);
    queue_op(OP_PEEK, '0, '0);
    queue_op(OP_PUSH, kb, ka);
    queue_op(OP_POP, '0, '0);
    drain();

    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_CAPACITY, CFG_DATA_W'(caps[p]));
      write_reg(CFG_ENABLED, (p == 4) ? CFG_DATA_W'(0) : CFG_DATA_W'(1));
      @(posedge clk);
      send_idle = (p < 3) ? 8 : ((p < 6) ? 65 : 0);
      recv_idle = (p < 3) ? 65 : ((p < 6) ? 8 : 0);
      repeat ((p == 4) ? 30 : 113) queue_random(FILL_W'(caps[p]));
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && ring_answers.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
